// ----- rtl/edf_pkg.sv -----
// Package with the types and constants shared by the scheduler modules.
package edf_pkg;

	localparam int ID_W     = 4;
	localparam int ID_COUNT = 16;
	localparam int CNT_W    = 5;
	localparam int TIME_W   = 32;
	localparam int REL_W    = 31;

	localparam logic [1:0] MODE_PLAIN  = 2'd0;
	localparam logic [1:0] MODE_RT     = 2'd1;
	localparam logic [1:0] MODE_TICK   = 2'd2;
	localparam logic [1:0] MODE_SELECT = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_REFUSED = 2'd1;
	localparam logic [1:0] ST_IDLE    = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SIMPLE,
		S_PROMOTE,
		S_CURRENT,
		S_DISPATCH,
		S_OUT
	} edf_state_t;

	typedef struct packed {
		logic capture;
		logic do_simple;
		logic do_promote;
		logic do_current;
		logic do_dispatch;
		logic load_out;
	} edf_cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       promote_ok;
		logic       out_free;
	} edf_sts_t;

endpackage

// ----- rtl/edf_task_scheduler_unit.sv -----
// Top level of the earliest-deadline-first task scheduler.
//
//  Channel | Direction | Handshake            | Fields
//  input   | in        | in_valid, in_stall   | mode, task_id, release_ms, rel_deadline_ms, yielded
//  output  | out       | out_valid, out_stall | status, dispatched, run_id, must_wait,
//          |           |                      | wait_until_ms, met_count, miss_count, now_ms
//
// A create or tick item goes from capture in idle through the simple step to the output
// state, which loads the result once the output register is free; the next item is taken
// after the return to idle. A select item passes instead through the promotion step, which
// moves one released waiting task per cycle, then the current-task and dispatch steps, then
// the output state. Reset empties all queues and clears the clock and the counters.
// A held result stays in the output register while the next item is taken in, and the
// following result waits until the held one has been taken.
module edf_task_scheduler_unit #(
	parameter int MAX_TASKS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 mode,
	input  logic [edf_pkg::ID_W-1:0]   task_id,
	input  logic [edf_pkg::REL_W-1:0]  release_ms,
	input  logic [edf_pkg::REL_W-1:0]  rel_deadline_ms,
	input  logic                       yielded,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 status,
	output logic                       dispatched,
	output logic [edf_pkg::ID_W-1:0]   run_id,
	output logic                       must_wait,
	output logic [edf_pkg::REL_W-1:0]  wait_until_ms,
	output logic [edf_pkg::TIME_W-1:0] met_count,
	output logic [edf_pkg::TIME_W-1:0] miss_count,
	output logic [edf_pkg::TIME_W-1:0] now_ms
);
	import edf_pkg::*;

	edf_cmd_t cmd;
	edf_sts_t sts;

	edf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	edf_dp #(
		.MAX_TASKS (MAX_TASKS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.mode            (mode),
		.task_id         (task_id),
		.release_ms      (release_ms),
		.rel_deadline_ms (rel_deadline_ms),
		.yielded         (yielded),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.dispatched      (dispatched),
		.run_id          (run_id),
		.must_wait       (must_wait),
		.wait_until_ms   (wait_until_ms),
		.met_count       (met_count),
		.miss_count      (miss_count),
		.now_ms          (now_ms)
	);

endmodule

// ----- rtl/edf_ctrl.sv -----
// Controller state machine that sequences one item through the datapath.
module edf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  edf_pkg::edf_sts_t sts,
	output edf_pkg::edf_cmd_t cmd
);
	import edf_pkg::*;

	edf_state_t state_q;
	edf_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_SIMPLE;
				end
			end
			S_SIMPLE: begin
				if (sts.mode == MODE_SELECT) begin
					state_d = S_PROMOTE;
				end else begin
					state_d = S_OUT;
				end
			end
			S_PROMOTE: begin
				if (!sts.promote_ok) begin
					state_d = S_CURRENT;
				end
			end
			S_CURRENT:  state_d = S_DISPATCH;
			S_DISPATCH: state_d = S_OUT;
			S_OUT: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			S_SIMPLE:   cmd.do_simple   = (sts.mode != MODE_SELECT);
			S_PROMOTE:  cmd.do_promote  = sts.promote_ok;
			S_CURRENT:  cmd.do_current  = 1'b1;
			S_DISPATCH: cmd.do_dispatch = 1'b1;
			S_OUT:      cmd.load_out    = sts.out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ----- rtl/edf_dp.sv -----
// Datapath holding the task slots, the three queues, the clock and the counters.
module edf_dp #(
	parameter int MAX_TASKS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  edf_pkg::edf_cmd_t             cmd,
	output edf_pkg::edf_sts_t             sts,
	input  logic [1:0]                    mode,
	input  logic [edf_pkg::ID_W-1:0]      task_id,
	input  logic [edf_pkg::REL_W-1:0]     release_ms,
	input  logic [edf_pkg::REL_W-1:0]     rel_deadline_ms,
	input  logic                          yielded,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic                          dispatched,
	output logic [edf_pkg::ID_W-1:0]      run_id,
	output logic                          must_wait,
	output logic [edf_pkg::REL_W-1:0]     wait_until_ms,
	output logic [edf_pkg::TIME_W-1:0]    met_count,
	output logic [edf_pkg::TIME_W-1:0]    miss_count,
	output logic [edf_pkg::TIME_W-1:0]    now_ms
);
	import edf_pkg::*;

	localparam int CAP = (MAX_TASKS < ID_COUNT) ? MAX_TASKS : ID_COUNT;
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAP);

	logic [1:0]        mode_q;
	logic [ID_W-1:0]   id_q;
	logic [REL_W-1:0]  rel_q;
	logic [REL_W-1:0]  dl_q;
	logic              yld_q;

	logic [TIME_W-1:0]   clock_q;
	logic [ID_COUNT-1:0] used_q;
	logic [CNT_W-1:0]    busy_q;

	logic [ID_W-1:0]   rdy_id_q  [ID_COUNT];
	logic [TIME_W-1:0] rdy_key_q [ID_COUNT];
	logic [CNT_W-1:0]  rdy_cnt_q;
	logic [ID_W-1:0]   wt_id_q   [ID_COUNT];
	logic [REL_W-1:0]  wt_rel_q  [ID_COUNT];
	logic [TIME_W-1:0] wt_dl_q   [ID_COUNT];
	logic [CNT_W-1:0]  wt_cnt_q;
	logic [ID_W-1:0]   ff_id_q   [ID_COUNT];
	logic [CNT_W-1:0]  ff_cnt_q;

	logic [ID_W-1:0]   run_id_q;
	logic              run_rt_q;
	logic [TIME_W-1:0] run_dl_q;
	logic              run_vld_q;
	logic [TIME_W-1:0] met_q;
	logic [TIME_W-1:0] miss_q;

	logic [1:0]        res_status_q;
	logic              res_disp_q;
	logic [ID_W-1:0]   res_run_q;
	logic              res_mw_q;
	logic [REL_W-1:0]  res_wait_q;
	logic              out_valid_q;

	logic [TIME_W-1:0] abs_dl;
	logic              refused;
	logic              released;
	logic              out_free;

	logic              rdy_ins;
	logic [ID_W-1:0]   rdy_ins_id;
	logic [TIME_W-1:0] rdy_ins_key;
	logic              rdy_pop;
	logic [ID_COUNT-1:0] rdy_lt;
	logic              wt_ins;
	logic              wt_pop;
	logic [ID_COUNT-1:0] wt_lt;
	logic              ff_push;
	logic [ID_W-1:0]   ff_push_id;
	logic              ff_pop;

	assign abs_dl   = {1'b0, rel_q} + {1'b0, dl_q};
	assign refused  = used_q[id_q] || (busy_q >= CAP_C);
	assign released = ({1'b0, rel_q} <= clock_q);
	assign out_free = !out_valid_q || !out_stall;

	assign sts.mode       = mode_q;
	assign sts.promote_ok = (wt_cnt_q != '0) && ({1'b0, wt_rel_q[0]} <= clock_q);
	assign sts.out_free   = out_free;

	always_comb begin
		rdy_ins     = 1'b0;
		rdy_ins_id  = id_q;
		rdy_ins_key = abs_dl;
		wt_ins      = 1'b0;
		ff_push     = 1'b0;
		ff_push_id  = id_q;
		rdy_pop     = 1'b0;
		wt_pop      = 1'b0;
		ff_pop      = 1'b0;
		if (cmd.do_simple && !refused) begin
			if (mode_q == MODE_PLAIN) begin
				ff_push = 1'b1;
			end else if (mode_q == MODE_RT) begin
				rdy_ins = released;
				wt_ins  = !released;
			end
		end
		if (cmd.do_promote) begin
			rdy_ins     = 1'b1;
			rdy_ins_id  = wt_id_q[0];
			rdy_ins_key = wt_dl_q[0];
			wt_pop      = 1'b1;
		end
		if (cmd.do_current && run_vld_q && yld_q) begin
			if (run_rt_q) begin
				rdy_ins     = 1'b1;
				rdy_ins_id  = run_id_q;
				rdy_ins_key = run_dl_q;
			end else begin
				ff_push    = 1'b1;
				ff_push_id = run_id_q;
			end
		end
		if (cmd.do_dispatch) begin
			if (rdy_cnt_q != '0) begin
				rdy_pop = 1'b1;
			end else if (ff_cnt_q != '0) begin
				ff_pop = 1'b1;
			end else if (wt_cnt_q != '0) begin
				wt_pop = 1'b1;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < ID_COUNT; i++) begin
			rdy_lt[i] = (CNT_W'(i) < rdy_cnt_q) && (rdy_key_q[i] < rdy_ins_key);
			wt_lt[i]  = (CNT_W'(i) < wt_cnt_q) && (wt_rel_q[i] < rel_q);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < ID_COUNT; i++) begin
			if (rdy_ins) begin
				if (!rdy_lt[i]) begin
					if (i == 0 || rdy_lt[(i == 0) ? 0 : i-1]) begin
						rdy_id_q[i]  <= rdy_ins_id;
						rdy_key_q[i] <= rdy_ins_key;
					end else begin
						rdy_id_q[i]  <= rdy_id_q[(i == 0) ? 0 : i-1];
						rdy_key_q[i] <= rdy_key_q[(i == 0) ? 0 : i-1];
					end
				end
			end else if (rdy_pop && i < ID_COUNT-1) begin
				rdy_id_q[i]  <= rdy_id_q[(i < ID_COUNT-1) ? i+1 : i];
				rdy_key_q[i] <= rdy_key_q[(i < ID_COUNT-1) ? i+1 : i];
			end
			if (wt_ins) begin
				if (!wt_lt[i]) begin
					if (i == 0 || wt_lt[(i == 0) ? 0 : i-1]) begin
						wt_id_q[i]  <= id_q;
						wt_rel_q[i] <= rel_q;
						wt_dl_q[i]  <= abs_dl;
					end else begin
						wt_id_q[i]  <= wt_id_q[(i == 0) ? 0 : i-1];
						wt_rel_q[i] <= wt_rel_q[(i == 0) ? 0 : i-1];
						wt_dl_q[i]  <= wt_dl_q[(i == 0) ? 0 : i-1];
					end
				end
			end else if (wt_pop && i < ID_COUNT-1) begin
				wt_id_q[i]  <= wt_id_q[(i < ID_COUNT-1) ? i+1 : i];
				wt_rel_q[i] <= wt_rel_q[(i < ID_COUNT-1) ? i+1 : i];
				wt_dl_q[i]  <= wt_dl_q[(i < ID_COUNT-1) ? i+1 : i];
			end
			if (ff_pop && i < ID_COUNT-1) begin
				ff_id_q[i] <= ff_id_q[(i < ID_COUNT-1) ? i+1 : i];
			end
		end
		if (ff_push) begin
			ff_id_q[ff_cnt_q[ID_W-1:0]] <= ff_push_id;
		end
		if (cmd.capture) begin
			mode_q <= mode;
			id_q   <= task_id;
			rel_q  <= release_ms;
			dl_q   <= rel_deadline_ms;
			yld_q  <= yielded;
		end
		if (cmd.do_simple) begin
			res_status_q <= (mode_q != MODE_TICK && refused) ? ST_REFUSED : ST_OK;
			res_disp_q   <= 1'b0;
			res_run_q    <= '0;
			res_mw_q     <= 1'b0;
			res_wait_q   <= '0;
		end
		if (cmd.do_dispatch) begin
			res_status_q <= ST_OK;
			res_disp_q   <= 1'b1;
			res_mw_q     <= 1'b0;
			res_wait_q   <= '0;
			if (rdy_cnt_q != '0) begin
				res_run_q <= rdy_id_q[0];
				run_id_q  <= rdy_id_q[0];
				run_rt_q  <= 1'b1;
				run_dl_q  <= rdy_key_q[0];
			end else if (ff_cnt_q != '0) begin
				res_run_q <= ff_id_q[0];
				run_id_q  <= ff_id_q[0];
				run_rt_q  <= 1'b0;
			end else if (wt_cnt_q != '0) begin
				res_run_q  <= wt_id_q[0];
				run_id_q   <= wt_id_q[0];
				run_rt_q   <= 1'b1;
				run_dl_q   <= wt_dl_q[0];
				res_mw_q   <= 1'b1;
				res_wait_q <= wt_rel_q[0];
			end else begin
				res_status_q <= ST_IDLE;
				res_disp_q   <= 1'b0;
				res_run_q    <= '0;
			end
		end
		if (cmd.load_out) begin
			status        <= res_status_q;
			dispatched    <= res_disp_q;
			run_id        <= res_run_q;
			must_wait     <= res_mw_q;
			wait_until_ms <= res_wait_q;
			met_count     <= met_q;
			miss_count    <= miss_q;
			now_ms        <= clock_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q     <= '0;
			used_q      <= '0;
			busy_q      <= '0;
			rdy_cnt_q   <= '0;
			wt_cnt_q    <= '0;
			ff_cnt_q    <= '0;
			run_vld_q   <= 1'b0;
			met_q       <= '0;
			miss_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.do_simple) begin
				if (mode_q == MODE_TICK) begin
					if (clock_q != '1) begin
						clock_q <= clock_q + 1'b1;
					end
				end else if (!refused) begin
					used_q[id_q] <= 1'b1;
					busy_q       <= busy_q + 1'b1;
				end
			end
			if (cmd.do_current && run_vld_q) begin
				run_vld_q <= 1'b0;
				if (!yld_q) begin
					used_q[run_id_q] <= 1'b0;
					busy_q           <= busy_q - 1'b1;
					if (run_rt_q) begin
						if (clock_q <= run_dl_q) begin
							if (met_q != '1) begin
								met_q <= met_q + 1'b1;
							end
						end else if (miss_q != '1) begin
							miss_q <= miss_q + 1'b1;
						end
					end
				end
			end
			if (cmd.do_dispatch) begin
				run_vld_q <= (rdy_cnt_q != '0) || (ff_cnt_q != '0) || (wt_cnt_q != '0);
			end
			if (rdy_ins && !rdy_pop) begin
				rdy_cnt_q <= rdy_cnt_q + 1'b1;
			end else if (rdy_pop && !rdy_ins) begin
				rdy_cnt_q <= rdy_cnt_q - 1'b1;
			end
			if (wt_ins) begin
				wt_cnt_q <= wt_cnt_q + 1'b1;
			end else if (wt_pop) begin
				wt_cnt_q <= wt_cnt_q - 1'b1;
			end
			if (ff_push) begin
				ff_cnt_q <= ff_cnt_q + 1'b1;
			end else if (ff_pop) begin
				ff_cnt_q <= ff_cnt_q - 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
